// File: src/sacc_pkg.sv
`timescale 1ns / 1ps

package sacc_pkg;

    // Default geometry
    localparam int INDEX_BITS_DEF  = 8;
    localparam int OFFSET_BITS_DEF = 4;
    localparam int WAYS_DEF        = 4;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int AGE_W       = 8;
    localparam int COST_W      = 9;
    localparam int WAY_FIELD_W = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

    // Cost figures
    localparam int HIT_COST       = 1;
    localparam int BYTE_FILL_COST = 25;
    localparam int MEM_WRITE_COST = 100;
    localparam int COST_MAX       = 511;

    // Configuration register indexes (index 3 is ignored)
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WRITE_ALLOCATE = 2'd0,
        CFG_WRITE_THROUGH  = 2'd1,
        CFG_USE_LRU        = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_STORE = 1'b1
    } op_t;

    // Request item
    typedef struct packed {
        op_t               opcode;
        logic [ADDR_W-1:0] address;
    } req_t;

    // Response item
    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] way;
        logic                   allocated;
        logic                   evicted;
        logic                   evicted_dirty;
        logic [COST_W-1:0]      cycle_cost;
    } rsp_t;

    // Result of the shared way unit
    typedef struct packed {
        logic             match;
        logic             older;
        logic [AGE_W-1:0] age;
    } way_res_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

// File: src/sacc_set_mem.sv
`timescale 1ns / 1ps

// One row per set: all ways of the set plus its fill count.
module sacc_set_mem #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_W    = 8
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_W-1:0]    rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_W-1:0]    wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/sacc_way_unit.sv
`timescale 1ns / 1ps

// Shared per-way unit: ages one line, compares its tag, compares its age
// against the oldest seen so far in the set.
module sacc_way_unit #(
    parameter int TAG_W = 20
) (
    input  logic                       valid,
    input  logic [TAG_W-1:0]           line_tag,
    input  logic [sacc_pkg::AGE_W-1:0] line_age,
    input  logic [TAG_W-1:0]           req_tag,
    input  logic [sacc_pkg::AGE_W-1:0] best_age,
    output sacc_pkg::way_res_t         res
);

    logic [sacc_pkg::AGE_W-1:0] aged;

    // Saturating age step for valid lines
    always_comb
    begin
        if (valid && (line_age != sacc_pkg::AGE_MAX))
        begin
            aged = line_age + 1'b1;
        end
        else
        begin
            aged = line_age;
        end
    end

    assign res.age   = aged;
    assign res.match = valid && (line_tag == req_tag);
    assign res.older = (aged > best_age);

endmodule

// File: src/set_assoc_cache_controller_core.sv
`timescale 1ns / 1ps

// Channel | Signals                          | Item
// --------+----------------------------------+------------------------------
// request | req_valid, req_stall, req        | opcode, address
// response| rsp_valid, rsp_stall, rsp        | hit, way, flags, cycle_cost
// config  | cfg_valid, cfg_ready, cfg_index, | register index, bit 0 value
//         | cfg_data                         |
//
// Each access passes the states READ, SCAN, DECIDE, UPDATE and DONE before the
// next acceptance: the set row is read, then the shared way unit visits one way per
// cycle in a scan pass (aging, tag match, victim search) and again in an update pass.
// After reset a clearing pass empties every row of the set memory;
// req_stall stays high during it. A finished result waits in the response
// register while the next item is accepted; rsp_stall only holds a new result
// back once that register is still full.
module set_assoc_cache_controller_core #(
    parameter int INDEX_BITS  = sacc_pkg::INDEX_BITS_DEF,
    parameter int OFFSET_BITS = sacc_pkg::OFFSET_BITS_DEF,
    parameter int WAYS        = sacc_pkg::WAYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  sacc_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output sacc_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sacc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data
);

    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int SET_AW   = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_W    = sacc_pkg::ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FC_W     = $clog2(WAYS + 1);
    localparam int AGE_W    = sacc_pkg::AGE_W;
    localparam int COST_W   = sacc_pkg::COST_W;
    localparam int WAY_FIELD_W = sacc_pkg::WAY_FIELD_W;

    // Cost figures, saturated at elaboration
    localparam int FILL_RAW   = sacc_pkg::BYTE_FILL_COST * (1 << OFFSET_BITS) + 1;
    localparam int FILL_WT    = FILL_RAW + sacc_pkg::MEM_WRITE_COST;
    localparam int HIT_WT     = sacc_pkg::HIT_COST + sacc_pkg::MEM_WRITE_COST;
    localparam int FILL_SAT   = (FILL_RAW > sacc_pkg::COST_MAX) ? sacc_pkg::COST_MAX
                                                                 : FILL_RAW;
    localparam int FILL_WTSAT = (FILL_WT > sacc_pkg::COST_MAX) ? sacc_pkg::COST_MAX
                                                                : FILL_WT;
    localparam logic [COST_W-1:0] COST_HIT    = COST_W'(sacc_pkg::HIT_COST);
    localparam logic [COST_W-1:0] COST_HIT_WT = COST_W'(HIT_WT);
    localparam logic [COST_W-1:0] COST_FILL   = COST_W'(FILL_SAT);
    localparam logic [COST_W-1:0] COST_FILLWT = COST_W'(FILL_WTSAT);
    localparam logic [COST_W-1:0] COST_AROUND = COST_W'(sacc_pkg::MEM_WRITE_COST);

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } line_t;

    typedef struct packed {
        logic [FC_W-1:0]        fc;
        line_t [WAYS-1:0]       lines;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Configuration registers
    logic wr_alloc_reg;
    logic wr_through_reg;
    logic use_lru_reg;

    // Sequencer and datapath registers
    sacc_pkg::state_t state_reg, state_next;
    logic [SET_AW-1:0] clr_cnt_reg;
    logic [SET_AW-1:0] set_reg, set_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              store_reg, store_next;
    line_t [WAYS-1:0]  lines_reg, lines_next;
    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [WAY_W-1:0]  cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic [WAY_W-1:0]  hway_reg, hway_next;
    logic [AGE_W-1:0]  best_age_reg, best_age_next;
    logic [WAY_W-1:0]  best_way_reg, best_way_next;
    logic              best_valid_reg, best_valid_next;
    logic              best_dirty_reg, best_dirty_next;
    logic              upd_en_reg, upd_en_next;
    logic              upd_fill_reg, upd_fill_next;
    logic [WAY_W-1:0]  upd_way_reg, upd_way_next;
    sacc_pkg::rsp_t    res_reg, res_next;
    logic              rsp_valid_reg;
    sacc_pkg::rsp_t    rsp_reg;

    // Control strobes
    logic              req_accept;
    logic              rsp_free;
    logic              rsp_load;
    logic              cnt_last;
    logic              clr_last;
    logic              mem_rd_en;
    logic              mem_wr_en;
    logic [SET_AW-1:0] mem_wr_addr;
    logic [ROW_W-1:0]  mem_wr_data;
    logic [ROW_W-1:0]  mem_rd_data;
    row_t              rd_row;
    logic [SET_AW-1:0] req_set;
    logic [TAG_W-1:0]  req_tag;
    line_t             head;
    line_t             head_new;
    sacc_pkg::way_res_t wres;

    // Address split
    generate
        if (INDEX_BITS > 0)
        begin : g_idx
            assign req_set = req.address[OFFSET_BITS +: INDEX_BITS];
        end
        else
        begin : g_noidx
            assign req_set = '0;
        end
    endgenerate

    assign req_tag = req.address[sacc_pkg::ADDR_W-1 -: TAG_W];

    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign cnt_last   = (cnt_reg == WAY_W'(WAYS - 1));
    assign clr_last   = (clr_cnt_reg == SET_AW'(NUM_SETS - 1));
    assign rd_row     = row_t'(mem_rd_data);
    assign head       = lines_reg[0];

    // Set memory
    sacc_set_mem #(
        .ADDR_BITS (SET_AW),
        .DATA_W    (ROW_W)
    ) u_set_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (req_set),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Shared way unit, always looking at the head of the row buffer
    sacc_way_unit #(
        .TAG_W (TAG_W)
    ) u_way_unit (
        .valid    (head.valid),
        .line_tag (head.tag),
        .line_age (head.age),
        .req_tag  (tag_reg),
        .best_age (best_age_reg),
        .res      (wres)
    );

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_alloc_reg   <= 1'b1;
            wr_through_reg <= 1'b0;
            use_lru_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sacc_pkg::CFG_WRITE_ALLOCATE: wr_alloc_reg   <= cfg_data;
                sacc_pkg::CFG_WRITE_THROUGH:  wr_through_reg <= cfg_data;
                sacc_pkg::CFG_USE_LRU:        use_lru_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sacc_pkg::ST_CLEAR:  if (clr_last) state_next = sacc_pkg::ST_IDLE;
            sacc_pkg::ST_IDLE:   if (req_accept) state_next = sacc_pkg::ST_READ;
            sacc_pkg::ST_READ:   state_next = sacc_pkg::ST_SCAN;
            sacc_pkg::ST_SCAN:   if (cnt_last) state_next = sacc_pkg::ST_DECIDE;
            sacc_pkg::ST_DECIDE: state_next = sacc_pkg::ST_UPDATE;
            sacc_pkg::ST_UPDATE: if (cnt_last) state_next = sacc_pkg::ST_DONE;
            sacc_pkg::ST_DONE:   if (rsp_free) state_next = sacc_pkg::ST_IDLE;
            default:             state_next = sacc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_stall   = 1'b1;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = set_reg;
        mem_wr_data = ROW_W'({fc_reg, lines_reg});
        rsp_load    = 1'b0;
        unique case (state_reg)
            sacc_pkg::ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                mem_wr_data = '0;
            end
            sacc_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                mem_rd_en = req_valid;
            end
            sacc_pkg::ST_DONE:
            begin
                mem_wr_en = rsp_free;
                rsp_load  = rsp_free;
            end
            default: ;
        endcase
    end

    // Head line after the update pass touches it
    always_comb
    begin
        head_new = head;
        if (upd_en_reg && (cnt_reg == upd_way_reg))
        begin
            if (upd_fill_reg)
            begin
                head_new.tag   = tag_reg;
                head_new.valid = 1'b1;
                head_new.age   = '0;
                head_new.dirty = store_reg && !wr_through_reg;
            end
            else
            begin
                if (use_lru_reg)
                begin
                    head_new.age = '0;
                end
                if (store_reg && !wr_through_reg)
                begin
                    head_new.dirty = 1'b1;
                end
            end
        end
    end

    // Datapath next values
    always_comb
    begin
        set_next        = set_reg;
        tag_next        = tag_reg;
        store_next      = store_reg;
        lines_next      = lines_reg;
        fc_next         = fc_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        hway_next       = hway_reg;
        best_age_next   = best_age_reg;
        best_way_next   = best_way_reg;
        best_valid_next = best_valid_reg;
        best_dirty_next = best_dirty_reg;
        upd_en_next     = upd_en_reg;
        upd_fill_next   = upd_fill_reg;
        upd_way_next    = upd_way_reg;
        res_next        = res_reg;

        unique case (state_reg)
            sacc_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    set_next   = req_set;
                    tag_next   = req_tag;
                    store_next = (req.opcode == sacc_pkg::OP_STORE);
                end
            end

            // Row arrives from memory
            sacc_pkg::ST_READ:
            begin
                lines_next    = rd_row.lines;
                fc_next       = rd_row.fc;
                cnt_next      = '0;
                hit_next      = 1'b0;
                hway_next     = '0;
                best_age_next = '0;
            end

            // Age, match and victim search, one way per cycle
            sacc_pkg::ST_SCAN:
            begin
                if (wres.match && !hit_reg)
                begin
                    hit_next  = 1'b1;
                    hway_next = cnt_reg;
                end
                if (wres.older || (cnt_reg == '0))
                begin
                    best_age_next   = wres.age;
                    best_way_next   = cnt_reg;
                    best_valid_next = head.valid;
                    best_dirty_next = head.dirty;
                end
                for (int i = 0; i < WAYS - 1; i++)
                begin
                    lines_next[i] = lines_reg[i + 1];
                end
                lines_next[WAYS-1]     = head;
                lines_next[WAYS-1].age = wres.age;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end

            // Hit, fill or write around
            sacc_pkg::ST_DECIDE:
            begin
                res_next = '0;
                if (hit_reg)
                begin
                    upd_en_next   = 1'b1;
                    upd_fill_next = 1'b0;
                    upd_way_next  = hway_reg;
                    res_next.hit  = 1'b1;
                    res_next.way  = WAY_FIELD_W'(hway_reg);
                    res_next.cycle_cost = (store_reg && wr_through_reg) ? COST_HIT_WT
                                                                        : COST_HIT;
                end
                else if (!store_reg || wr_alloc_reg)
                begin
                    upd_en_next        = 1'b1;
                    upd_fill_next      = 1'b1;
                    res_next.allocated = 1'b1;
                    if (fc_reg != FC_W'(WAYS))
                    begin
                        upd_way_next = WAY_W'(fc_reg);
                        res_next.way = WAY_FIELD_W'(WAY_W'(fc_reg));
                        fc_next      = fc_reg + 1'b1;
                    end
                    else
                    begin
                        upd_way_next           = best_way_reg;
                        res_next.way           = WAY_FIELD_W'(best_way_reg);
                        res_next.evicted       = best_valid_reg;
                        res_next.evicted_dirty = best_valid_reg && best_dirty_reg;
                    end
                    res_next.cycle_cost = (store_reg && wr_through_reg) ? COST_FILLWT
                                                                        : COST_FILL;
                end
                else
                begin
                    upd_en_next         = 1'b0;
                    upd_fill_next       = 1'b0;
                    upd_way_next        = '0;
                    res_next.cycle_cost = COST_AROUND;
                end
            end

            // Apply the line update while rotating back into order
            sacc_pkg::ST_UPDATE:
            begin
                for (int i = 0; i < WAYS - 1; i++)
                begin
                    lines_next[i] = lines_reg[i + 1];
                end
                lines_next[WAYS-1] = head_new;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end

            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sacc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == sacc_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        set_reg        <= set_next;
        tag_reg        <= tag_next;
        store_reg      <= store_next;
        lines_reg      <= lines_next;
        fc_reg         <= fc_next;
        hit_reg        <= hit_next;
        hway_reg       <= hway_next;
        best_age_reg   <= best_age_next;
        best_way_reg   <= best_way_next;
        best_valid_reg <= best_valid_next;
        best_dirty_reg <= best_dirty_next;
        upd_en_reg     <= upd_en_next;
        upd_fill_reg   <= upd_fill_next;
        upd_way_reg    <= upd_way_next;
        res_reg        <= res_next;
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: dv/set_assoc_cache_controller_core_tb.sv
`timescale 1ns / 1ps

module set_assoc_cache_controller_core_tb;

    import sacc_pkg::*;

    localparam int SETS        = 1 << INDEX_BITS_DEF;
    localparam int TAG_W       = ADDR_W - INDEX_BITS_DEF - OFFSET_BITS_DEF;
    localparam int FILL_COST   = BYTE_FILL_COST * (1 << OFFSET_BITS_DEF) + HIT_COST;
    localparam int ITEM_CYCLES = 2 * WAYS_DEF + 4;
    localparam int END_PAUSE   = ITEM_CYCLES + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam logic [CFG_INDEX_W-1:0]    CFG_IGNORED = 2'd3;
    localparam logic [INDEX_BITS_DEF-1:0] HOT_SET     = 8'h33;

    // One line of the directed plan: a register write or an access
    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] cfg_idx;
        logic                   cfg_val;
        req_t                   item;
        logic                   typed;
        rsp_t                   want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_t                   req       = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic                   cfg_data  = 1'b0;

    // Shadow copy of the cache bookkeeping
    logic [TAG_W-1:0] line_tag   [SETS][WAYS_DEF];
    logic             line_valid [SETS][WAYS_DEF];
    logic             line_dirty [SETS][WAYS_DEF];
    logic [AGE_W-1:0] line_age   [SETS][WAYS_DEF];
    int               fill_cnt   [SETS];
    logic             mode_write_allocate;
    logic             mode_write_through;
    logic             mode_lru;

    rsp_t      awaited_lookups[$];
    plan_row_t plan[$];

    int   errors       = 0;
    int   results_seen = 0;
    int   hits_seen    = 0;
    int   fills_seen   = 0;
    int   evicts_seen  = 0;
    int   dirty_seen   = 0;
    int   cfg_writes   = 0;
    logic no_idle      = 1'b0;
    logic held_off     = 1'b0;

    set_assoc_cache_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicts one access and updates the shadow state
    function automatic rsp_t cache_lookup(input req_t item);
        int                      s;
        int                      hw;
        int                      best;
        int                      cost;
        logic                    found;
        logic                    is_store;
        logic [TAG_W-1:0]        t;
        logic [AGE_W-1:0]        best_age;
        rsp_t                    r;
        s        = int'(item.address[OFFSET_BITS_DEF +: INDEX_BITS_DEF]);
        t        = item.address[ADDR_W-1 -: TAG_W];
        is_store = (item.opcode == OP_STORE);
        r        = '0;
        found    = 1'b0;
        hw       = 0;
        for (int w = 0; w < WAYS_DEF; w++)
            if (line_valid[s][w] && line_age[s][w] != AGE_MAX)
                line_age[s][w]++;
        for (int w = 0; w < WAYS_DEF; w++)
            if (!found && line_valid[s][w] && line_tag[s][w] == t)
            begin
                found = 1'b1;
                hw    = w;
            end
        if (found)
        begin
            r.hit = 1'b1;
            r.way = WAY_FIELD_W'(hw);
            cost  = HIT_COST;
            if (mode_lru)
                line_age[s][hw] = '0;
            if (is_store)
            begin
                if (mode_write_through)
                    cost += MEM_WRITE_COST;
                else
                    line_dirty[s][hw] = 1'b1;
            end
        end
        else if (!is_store || mode_write_allocate)
        begin
            r.allocated = 1'b1;
            if (fill_cnt[s] < WAYS_DEF)
            begin
                hw = fill_cnt[s];
                fill_cnt[s]++;
            end
            else
            begin
                // oldest way wins, lowest way on a tie
                best     = 0;
                best_age = '0;
                for (int w = 0; w < WAYS_DEF; w++)
                    if (line_age[s][w] > best_age)
                    begin
                        best_age = line_age[s][w];
                        best     = w;
                    end
                hw = best;
                if (line_valid[s][hw])
                begin
                    r.evicted       = 1'b1;
                    r.evicted_dirty = line_dirty[s][hw];
                end
            end
            line_tag[s][hw]   = t;
            line_valid[s][hw] = 1'b1;
            line_age[s][hw]   = '0;
            line_dirty[s][hw] = is_store && !mode_write_through;
            r.way             = WAY_FIELD_W'(hw);
            cost              = FILL_COST;
            if (is_store && mode_write_through)
                cost += MEM_WRITE_COST;
        end
        else
            cost = MEM_WRITE_COST;
        if (cost > COST_MAX)
            cost = COST_MAX;
        r.cycle_cost = COST_W'(cost);
        return r;
    endfunction

    function automatic rsp_t rsp_of(input logic h, input int w, input logic a,
                                    input logic ev, input logic evd, input int cost);
        rsp_t r;
        r.hit           = h;
        r.way           = WAY_FIELD_W'(w);
        r.allocated     = a;
        r.evicted       = ev;
        r.evicted_dirty = evd;
        r.cycle_cost    = COST_W'(cost);
        return r;
    endfunction

    function automatic plan_row_t access_row(input op_t op, input logic [ADDR_W-1:0] addr,
                                             input logic typed, input rsp_t want);
        plan_row_t row;
        row              = '0;
        row.item.opcode  = op;
        row.item.address = addr;
        row.typed        = typed;
        row.want         = want;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        plan_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Addresses folded onto a few sets and tags so that hits and evictions are common
    function automatic logic [ADDR_W-1:0] pick_address(input logic hot);
        logic [TAG_W-1:0]           t;
        logic [INDEX_BITS_DEF-1:0]  s;
        logic [OFFSET_BITS_DEF-1:0] o;
        logic [ADDR_W-1:0]          addr;
        o = OFFSET_BITS_DEF'($urandom);
        case ($urandom_range(0, 5))
            0:       t = '0;
            1:       t = '1;
            2:       t = 20'hA5A5A;
            3:       t = 20'h5A5A5;
            4:       t = 20'h00001;
            default: t = 20'h80000;
        endcase
        case ($urandom_range(0, 3))
            0:       s = '0;
            1:       s = '1;
            2:       s = 8'h5A;
            default: s = 8'hA5;
        endcase
        if (hot)
        begin
            // four resident tags, now and then a fifth one forces a replacement
            if ($urandom_range(0, 49) == 0)
                t = TAG_W'($urandom);
            else
                t = TAG_W'($urandom_range(0, 3));
            addr = {t, HOT_SET, o};
        end
        else if ($urandom_range(0, 9) < 7)
            addr = {t, s, o};
        else
            addr = $urandom;
        return addr;
    endfunction

    task automatic check_field(input string fname, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, fname, want_v, got_v);
        end
    endtask

    task automatic check_lookup(input rsp_t got);
        rsp_t want;
        if (awaited_lookups.size() == 0)
        begin
            errors++;
            $display("%0t ns: result with nothing awaited, got %h", $time, got);
        end
        else
        begin
            want = awaited_lookups.pop_front();
            check_field("hit", 32'(want.hit), 32'(got.hit));
            check_field("way", 32'(want.way), 32'(got.way));
            check_field("allocated", 32'(want.allocated), 32'(got.allocated));
            check_field("evicted", 32'(want.evicted), 32'(got.evicted));
            check_field("evicted_dirty", 32'(want.evicted_dirty), 32'(got.evicted_dirty));
            check_field("cycle_cost", 32'(want.cycle_cost), 32'(got.cycle_cost));
        end
        results_seen++;
        hits_seen   += int'(got.hit);
        fills_seen  += int'(got.allocated);
        evicts_seen += int'(got.evicted);
        dirty_seen  += int'(got.evicted_dirty);
    endtask

    // Entered and left at a falling edge
    task automatic send_item(input req_t item, input logic typed, input rsp_t want);
        int   gap;
        rsp_t predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = item;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = cache_lookup(item);
        awaited_lookups.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid = 1'b0;
        while (awaited_lookups.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_WRITE_ALLOCATE: mode_write_allocate = val;
            CFG_WRITE_THROUGH:  mode_write_through  = val;
            CFG_USE_LRU:        mode_lru            = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_mode(input logic wa, input logic wt, input logic lru);
        wait_idle();
        write_register(CFG_WRITE_ALLOCATE, wa);
        write_register(CFG_WRITE_THROUGH, wt);
        write_register(CFG_USE_LRU, lru);
    endtask

    task automatic run_phase(input int n, input logic hot);
        req_t item;
        for (int i = 0; i < n; i++)
        begin
            item.opcode  = op_t'($urandom_range(0, 1));
            item.address = pick_address(hot);
            send_item(item, 1'b0, '0);
        end
    endtask

    // Response side: random stalls plus one long hold-off to back the block up
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                check_lookup(rsp);
            @(negedge clk);
            if (!held_off && results_seen >= 150)
            begin
                held_off  = 1'b1;
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left == 0 && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
            rsp_stall = (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Watchdog on cycles without any handshake
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus
    initial
    begin
        for (int s = 0; s < SETS; s++)
        begin
            fill_cnt[s] = 0;
            for (int w = 0; w < WAYS_DEF; w++)
            begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_age[s][w]   = '0;
            end
        end
        mode_write_allocate = 1'b1;
        mode_write_through  = 1'b0;
        mode_lru            = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill set 0 then evict the dirty, oldest line
        plan.push_back(access_row(OP_LOAD, 32'h0000_0000, 1'b1, rsp_of(0, 0, 1, 0, 0, FILL_COST)));
        plan.push_back(access_row(OP_LOAD, 32'h0000_0004, 1'b1, rsp_of(1, 0, 0, 0, 0, HIT_COST)));
        plan.push_back(access_row(OP_STORE, 32'h0000_000F, 1'b1, rsp_of(1, 0, 0, 0, 0, HIT_COST)));
        plan.push_back(access_row(OP_LOAD, 32'hFFFF_FFFF, 1'b1, rsp_of(0, 0, 1, 0, 0, FILL_COST)));
        plan.push_back(access_row(OP_LOAD, 32'h0000_1000, 1'b1, rsp_of(0, 1, 1, 0, 0, FILL_COST)));
        plan.push_back(access_row(OP_LOAD, 32'h0000_2000, 1'b1, rsp_of(0, 2, 1, 0, 0, FILL_COST)));
        plan.push_back(access_row(OP_LOAD, 32'h0000_3000, 1'b1, rsp_of(0, 3, 1, 0, 0, FILL_COST)));
        plan.push_back(access_row(OP_LOAD, 32'h0000_4000, 1'b1, rsp_of(0, 0, 1, 1, 1, FILL_COST)));
        plan.push_back(access_row(OP_LOAD, 32'h0000_1000, 1'b0, '0));
        plan.push_back(access_row(OP_STORE, 32'h0000_5000, 1'b0, '0));
        // write around
        plan.push_back(cfg_row(CFG_WRITE_ALLOCATE, 1'b0));
        plan.push_back(access_row(OP_STORE, 32'h1234_5678, 1'b1,
                                  rsp_of(0, 0, 0, 0, 0, MEM_WRITE_COST)));
        plan.push_back(access_row(OP_STORE, 32'h0000_1000, 1'b0, '0));
        // write through, most expensive access
        plan.push_back(cfg_row(CFG_WRITE_THROUGH, 1'b1));
        plan.push_back(cfg_row(CFG_WRITE_ALLOCATE, 1'b1));
        plan.push_back(access_row(OP_STORE, 32'hABCD_E550, 1'b1,
                                  rsp_of(0, 0, 1, 0, 0, FILL_COST + MEM_WRITE_COST)));
        plan.push_back(access_row(OP_STORE, 32'hABCD_E55C, 1'b1,
                                  rsp_of(1, 0, 0, 0, 0, HIT_COST + MEM_WRITE_COST)));
        // fill order replacement
        plan.push_back(cfg_row(CFG_USE_LRU, 1'b0));
        plan.push_back(access_row(OP_LOAD, 32'h7FFF_FFF0, 1'b0, '0));
        plan.push_back(access_row(OP_LOAD, 32'hFFFF_FFF0, 1'b0, '0));
        plan.push_back(cfg_row(CFG_IGNORED, 1'b1));
        plan.push_back(access_row(OP_LOAD, 32'h8000_0000, 1'b0, '0));
        plan.push_back(access_row(OP_STORE, 32'h0000_0000, 1'b0, '0));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_register(plan[i].cfg_idx, plan[i].cfg_val);
            end
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        // every register combination, two of them without idling
        for (int m = 0; m < 8; m++)
        begin
            no_idle = (m == 3 || m == 6);
            set_mode(m[0], m[1], m[2]);
            run_phase(100, 1'b0);
        end
        no_idle = 1'b0;

        // one hot set in fill order mode: ages saturate and ties go to the lowest way
        set_mode(1'b1, 1'($urandom_range(0, 1)), 1'b0);
        run_phase(300, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            write_register(CFG_IGNORED, 1'($urandom_range(0, 1)));
            run_phase(100, 1'b0);
        end

        wait_idle();
        repeat (END_PAUSE) @(negedge clk);

        $display("covered %0d accesses: %0d hits, %0d fills, %0d evictions (%0d dirty)",
                 results_seen, hits_seen, fills_seen, evicts_seen, dirty_seen);
        $display("%0d register writes over all modes, a saturated hot set, one long hold-off",
                 cfg_writes);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
src/sacc_pkg.sv
src/sacc_set_mem.sv
src/sacc_way_unit.sv
src/set_assoc_cache_controller_core.sv
dv/set_assoc_cache_controller_core_tb.sv
